// ===== rtl/core/lbct_pkg.sv =====
// Package for the LRU block cache tag engine: field widths, opcodes and the
// request, result and tag-entry structs. No dependencies.
package lbct_pkg;

    localparam int DRIVE_W     = 2;
    localparam int PAGE_W      = 45;
    localparam int STAMP_W     = 64;
    localparam int CNT_W       = 32;
    localparam int SLOT_W      = 6;
    localparam int ENTRIES_DEF = 64;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INVAL  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [DRIVE_W-1:0] drive;
        logic [PAGE_W-1:0]  page;
        logic               fill_ok;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               filled;
        logic               evicted;
        logic               failed;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   miss_total;
        logic [CNT_W-1:0]   evict_total;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [DRIVE_W-1:0] drive;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

// ===== rtl/core/lbct_cell.sv =====
// One tag cell of the rotating entry ring: holds a valid bit, drive, page
// and stamp, and takes its neighbor's entry when the ring shifts. Uses lbct_pkg.
module lbct_cell
    import lbct_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  entry_t din,
    output entry_t dout
);

    logic               valid_reg;
    logic [DRIVE_W-1:0] drive_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [STAMP_W-1:0] stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            drive_reg <= '0;
        end
        else if (shift)
        begin
            valid_reg <= din.valid;
            drive_reg <= din.drive;
        end
    end

    // Page and stamp are only ever looked at for valid entries.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            page_reg  <= din.page;
            stamp_reg <= din.stamp;
        end
    end

    assign dout.valid = valid_reg;
    assign dout.drive = drive_reg;
    assign dout.page  = page_reg;
    assign dout.stamp = stamp_reg;

endmodule

// ===== rtl/core/lru_block_cache_tags.sv =====
// Top level of the LRU block cache tag engine: controller and the ring of
// lbct_cell entries. Uses lbct_pkg.
//
// A lookup runs a scan turn and an update turn before the done strobe, an
// invalidate only the scan turn. The entries sit in a ring of cells
// that rotates by one place per cycle past a single compare point at cell 0:
// the first full turn finds the hit, or the first free entry, or the entry
// with the oldest stamp (lowest index on ties), and invalidates by drive;
// the second turn writes the chosen entry back as it passes. busy stays high
// for the whole transaction. The result appears for exactly one cycle with
// done high and is not held, so the receiver must take it in that cycle.
// There is no clearing pass after reset.
module lru_block_cache_tags
    import lbct_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    logic                free_reg, free_next;
    logic [IW-1:0]       vic_idx_reg, vic_idx_next;
    logic [STAMP_W-1:0]  best_reg, best_next;
    logic                evict_flag_reg, evict_flag_next;
    logic [STAMP_W-1:0]  use_clock_reg, use_clock_next;
    logic [CNT_W-1:0]    hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]    miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]    evict_cnt_reg, evict_cnt_next;
    logic                done_reg, done_next;
    req_t                req_reg, req_next;
    rsp_t                rsp_reg, rsp_next;

    entry_t              ring [ENTRIES];
    entry_t              head;
    entry_t              wb;
    logic                shift;
    logic                last;
    logic                accept;
    logic                finish;
    logic                at_target;
    logic                match;
    logic [IW-1:0]       target;
    logic [STAMP_W-1:0]  new_stamp;

    assign head      = ring[0];
    assign shift     = (state_reg == ST_SCAN) || (state_reg == ST_UPDATE);
    assign last      = (idx_reg == LAST_IDX);
    assign accept    = start && (state_reg == ST_IDLE);
    assign target    = found_reg ? hit_idx_reg : vic_idx_reg;
    assign at_target = (state_reg == ST_UPDATE) && (idx_reg == target);
    assign new_stamp = use_clock_reg + STAMP_W'(1);
    assign match     = head.valid && (head.page == req_reg.page)
                       && (head.drive == req_reg.drive);
    assign finish    = last && (((state_reg == ST_SCAN) && (req_reg.opcode == OP_INVAL))
                       || (state_reg == ST_UPDATE));

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        entry_t cell_in;
        if (i == ENTRIES - 1)
        begin : g_tail
            assign cell_in = wb;
        end
        else
        begin : g_mid
            assign cell_in = ring[i+1];
        end
        lbct_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .din   (cell_in),
            .dout  (ring[i])
        );
    end

    // Entry written back into the tail of the ring as the head moves on.
    always_comb
    begin
        wb = head;
        if ((state_reg == ST_SCAN) && (req_reg.opcode == OP_INVAL)
            && (head.drive == req_reg.drive))
        begin
            wb.valid = 1'b0;
        end
        if (at_target)
        begin
            if (found_reg)
            begin
                wb.stamp = new_stamp;
            end
            else if (req_reg.fill_ok)
            begin
                wb.valid = 1'b1;
                wb.drive = req_reg.drive;
                wb.page  = req_reg.page;
                wb.stamp = new_stamp;
            end
            else
            begin
                wb.valid = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        free_next       = free_reg;
        vic_idx_next    = vic_idx_reg;
        best_next       = best_reg;
        evict_flag_next = evict_flag_reg;
        use_clock_next  = use_clock_reg;
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        evict_cnt_next  = evict_cnt_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        done_next       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next        = req;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_next       = 1'b0;
                    evict_flag_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match && !found_reg)
                begin
                    found_next   = 1'b1;
                    hit_idx_next = idx_reg;
                end
                if (!free_reg)
                begin
                    if (!head.valid)
                    begin
                        free_next    = 1'b1;
                        vic_idx_next = idx_reg;
                    end
                    else if ((idx_reg == '0) || (head.stamp < best_reg))
                    begin
                        best_next    = head.stamp;
                        vic_idx_next = idx_reg;
                    end
                end
                idx_next = last ? '0 : idx_reg + IW'(1);
                if (last)
                begin
                    state_next = (req_reg.opcode == OP_INVAL) ? ST_IDLE : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (at_target)
                begin
                    if (found_reg)
                    begin
                        use_clock_next = new_stamp;
                        hit_cnt_next   = (hit_cnt_reg == '1) ? hit_cnt_reg
                                         : hit_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        if (head.valid)
                        begin
                            evict_flag_next = 1'b1;
                            evict_cnt_next  = (evict_cnt_reg == '1) ? evict_cnt_reg
                                              : evict_cnt_reg + CNT_W'(1);
                        end
                        if (req_reg.fill_ok)
                        begin
                            use_clock_next = new_stamp;
                            miss_cnt_next  = (miss_cnt_reg == '1) ? miss_cnt_reg
                                             : miss_cnt_reg + CNT_W'(1);
                        end
                    end
                end
                idx_next = last ? '0 : idx_reg + IW'(1);
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next = 1'b1;
            if (req_reg.opcode == OP_INVAL)
            begin
                rsp_next.hit     = 1'b0;
                rsp_next.slot    = '0;
                rsp_next.filled  = 1'b0;
                rsp_next.evicted = 1'b0;
                rsp_next.failed  = 1'b0;
            end
            else
            begin
                rsp_next.hit     = found_reg;
                rsp_next.slot    = SLOT_W'(target);
                rsp_next.filled  = !found_reg && req_reg.fill_ok;
                rsp_next.evicted = evict_flag_next;
                rsp_next.failed  = !found_reg && !req_reg.fill_ok;
            end
            rsp_next.hit_total   = hit_cnt_next;
            rsp_next.miss_total  = miss_cnt_next;
            rsp_next.evict_total = evict_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_reg       <= 1'b0;
            evict_flag_reg <= 1'b0;
            use_clock_reg  <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_reg       <= free_next;
            evict_flag_reg <= evict_flag_next;
            use_clock_reg  <= use_clock_next;
            hit_cnt_reg    <= hit_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
            evict_cnt_reg  <= evict_cnt_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        rsp_reg     <= rsp_next;
        hit_idx_reg <= hit_idx_next;
        vic_idx_reg <= vic_idx_next;
        best_reg    <= best_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== rtl/core/lbct_checker.sv =====
// Port-level checker for lru_block_cache_tags, attached by the bind below.
// Uses lbct_pkg.
module lbct_checker
    import lbct_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // An accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // The result strobe comes only once the block is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_fill_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.filled && rsp.failed) && !(rsp.hit && rsp.evicted))
        else $error("contradictory result flags");

    // A reported event must already be counted in its total.
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!rsp.hit || rsp.hit_total != '0)
                 && (!rsp.evicted || rsp.evict_total != '0)
                 && (!rsp.filled || rsp.miss_total != '0))
        else $error("result flag without its count");

endmodule

bind lru_block_cache_tags lbct_checker u_lbct_checker (.*);
